[rtl/core/gray_box_downscaler_defines.svh]
// ---------------------------------------------------------------------------
// gray_box_downscaler assertion macros
// Shorthand for clocked implication checks used at the top level.
// ---------------------------------------------------------------------------
`ifndef GRAY_BOX_DOWNSCALER_DEFINES_SVH
`define GRAY_BOX_DOWNSCALER_DEFINES_SVH

// same-cycle implication
`define GBD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define GBD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/gbd_pkg.sv]
// ---------------------------------------------------------------------------
// gbd_pkg
// Widths, reciprocal tables and shared types of the gray box downscaler.
// ---------------------------------------------------------------------------
package gbd_pkg;

   localparam int MAX_INPUT_WIDTH = 1024;
   localparam int COL_W           = $clog2(MAX_INPUT_WIDTH);
   localparam int ROW_W           = 12;
   localparam int WID_W           = 11;
   localparam int HGT_W           = 13;
   localparam int FAC_W           = 5;
   localparam int BLK_W           = 4;
   localparam int PIX_W           = 8;
   localparam int CH_SUM_W        = 10;
   localparam int SUM_W           = 16;
   localparam int CSR_IDX_W       = 2;
   localparam int CSR_DATA_W      = 13;

   // gray = (r+g+b)/3 via multiply by ceil(2^11/3), exact for sums below 1024
   localparam int CHANNELS   = 3;
   localparam int GRAY_SH    = 11;
   localparam int GRAY_RECIP = ((1 << GRAY_SH) + CHANNELS - 1) / CHANNELS;
   localparam int GRAY_W     = CH_SUM_W + GRAY_SH - 1;

   // n/f via ceil(2^17/f), exact for n below 8192
   localparam int RECIP_W  = 18;
   localparam int RECIP_SH = 17;
   // n/(f*f) via ceil(2^24/f^2), exact for n below 65536
   localparam int SQ_RECIP_W  = 25;
   localparam int SQ_RECIP_SH = 24;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [CSR_IDX_W-1:0] CSR_INPUT_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INPUT_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_FACTOR = 2'd2;

   typedef struct packed {
      logic [FAC_W-1:0] factor;
      logic [WID_W-1:0] width;
      logic [HGT_W-1:0] height;
   } cfg_type;

   typedef struct packed {
      logic [COL_W-1:0] column;
      logic             first;
      logic             emit;
      logic             last;
      logic [PIX_W-1:0] gray;
   } qent_type;

   function automatic logic [RECIP_W-1:0] col_recip(input logic [FAC_W-1:0] f);
      logic [RECIP_W-1:0] m;
      case (f)
         5'd1:    m = 18'd131072;
         5'd2:    m = 18'd65536;
         5'd3:    m = 18'd43691;
         5'd4:    m = 18'd32768;
         5'd5:    m = 18'd26215;
         5'd6:    m = 18'd21846;
         5'd7:    m = 18'd18725;
         5'd8:    m = 18'd16384;
         5'd9:    m = 18'd14564;
         5'd10:   m = 18'd13108;
         5'd11:   m = 18'd11916;
         5'd12:   m = 18'd10923;
         5'd13:   m = 18'd10083;
         5'd14:   m = 18'd9363;
         5'd15:   m = 18'd8739;
         default: m = 18'd8192;
      endcase
      return m;
   endfunction

   function automatic logic [SQ_RECIP_W-1:0] sq_recip(input logic [FAC_W-1:0] f);
      logic [SQ_RECIP_W-1:0] m;
      case (f)
         5'd1:    m = 25'd16777216;
         5'd2:    m = 25'd4194304;
         5'd3:    m = 25'd1864136;
         5'd4:    m = 25'd1048576;
         5'd5:    m = 25'd671089;
         5'd6:    m = 25'd466034;
         5'd7:    m = 25'd342393;
         5'd8:    m = 25'd262144;
         5'd9:    m = 25'd207127;
         5'd10:   m = 25'd167773;
         5'd11:   m = 25'd138655;
         5'd12:   m = 25'd116509;
         5'd13:   m = 25'd99274;
         5'd14:   m = 25'd85599;
         5'd15:   m = 25'd74566;
         default: m = 25'd65536;
      endcase
      return m;
   endfunction

endpackage

[rtl/core/gbd_ram.sv]
// ---------------------------------------------------------------------------
// gbd_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module gbd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read during write returns the old word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/gbd_front.sv]
// ---------------------------------------------------------------------------
// gbd_front
// Raster counters, gray conversion and block classification of each pixel.
// ---------------------------------------------------------------------------
module gbd_front (
   input  logic                       clock,
   input  logic                       reset,
   input  gbd_pkg::cfg_type           cfg,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [gbd_pkg::PIX_W-1:0]  req_red,
   input  logic [gbd_pkg::PIX_W-1:0]  req_green,
   input  logic [gbd_pkg::PIX_W-1:0]  req_blue,
   input  logic                       q_full,
   output logic                       q_push,
   output gbd_pkg::qent_type          q_ent
);
   import gbd_pkg::*;

   logic [COL_W-1:0]    cp_ff, cp_in;
   logic [ROW_W-1:0]    rp_ff, rp_in;
   logic [BLK_W-1:0]    cib_ff, cib_in;
   logic [BLK_W-1:0]    rib_ff, rib_in;
   logic                f1_valid_ff, f1_valid_in;
   logic [COL_W-1:0]    f1_col_ff, f1_col_in;
   logic [ROW_W-1:0]    f1_row_ff, f1_row_in;
   logic [BLK_W-1:0]    f1_cib_ff, f1_cib_in;
   logic [BLK_W-1:0]    f1_rib_ff, f1_rib_in;
   logic [CH_SUM_W-1:0] f1_s3_ff, f1_s3_in;
   logic [WID_W-1:0]    wq_ff, wq_in;
   logic [HGT_W-1:0]    hq_ff, hq_in;

   logic                accept;
   logic [COL_W-1:0]    col;
   logic [ROW_W-1:0]    row;
   logic [BLK_W-1:0]    cib;
   logic [BLK_W-1:0]    rib;
   logic [WID_W-1:0]    col_nx;
   logic [HGT_W-1:0]    row_nx;
   logic [FAC_W-1:0]    cib_nx;
   logic [FAC_W-1:0]    rib_nx;
   logic [RECIP_W-1:0]  mcol;
   logic [WID_W+RECIP_W-1:0] w_prod;
   logic [HGT_W+RECIP_W-1:0] h_prod;
   logic [COL_W+RECIP_W-1:0] c_prod;
   logic [ROW_W+RECIP_W-1:0] r_prod;
   logic [GRAY_W:0]          g_prod;
   logic [COL_W-1:0]    colq;
   logic [ROW_W-1:0]    rowq;
   logic [FAC_W-1:0]    f_m1;

   assign req_stall = f1_valid_ff && q_full;
   assign accept    = req_valid && !req_stall;
   assign q_push    = f1_valid_ff && !q_full;
   assign mcol      = col_recip(cfg.factor);

   always_comb begin
      col    = ({1'b0, cp_ff} >= cfg.width) ? '0 : cp_ff;
      row    = ({1'b0, rp_ff} >= cfg.height) ? '0 : rp_ff;
      cib    = ({1'b0, cib_ff} >= cfg.factor) ? '0 : cib_ff;
      rib    = ({1'b0, rib_ff} >= cfg.factor) ? '0 : rib_ff;
      col_nx = {1'b0, col} + WID_W'(1);
      row_nx = {1'b0, row} + HGT_W'(1);
      cib_nx = {1'b0, cib} + FAC_W'(1);
      rib_nx = {1'b0, rib} + FAC_W'(1);

      cp_in  = cp_ff;
      rp_in  = rp_ff;
      cib_in = cib_ff;
      rib_in = rib_ff;
      if (accept) begin
         if (col_nx >= cfg.width) begin
            cp_in  = '0;
            cib_in = '0;
            if (row_nx >= cfg.height) begin
               rp_in  = '0;
               rib_in = '0;
            end else begin
               rp_in  = row_nx[ROW_W-1:0];
               rib_in = (rib_nx >= cfg.factor) ? '0 : rib_nx[BLK_W-1:0];
            end
         end else begin
            cp_in  = col_nx[COL_W-1:0];
            cib_in = (cib_nx >= cfg.factor) ? '0 : cib_nx[BLK_W-1:0];
            rp_in  = row;
            rib_in = rib;
         end
      end

      f1_valid_in = f1_valid_ff;
      if (accept) begin
         f1_valid_in = 1'b1;
      end else if (q_push) begin
         f1_valid_in = 1'b0;
      end
      f1_col_in = accept ? col : f1_col_ff;
      f1_row_in = accept ? row : f1_row_ff;
      f1_cib_in = accept ? cib : f1_cib_ff;
      f1_rib_in = accept ? rib : f1_rib_ff;
      f1_s3_in  = accept ? (CH_SUM_W'(req_red) + CH_SUM_W'(req_green) + CH_SUM_W'(req_blue))
                         : f1_s3_ff;
   end

   // per-frame block counts, refreshed every cycle from the registers
   always_comb begin
      w_prod = (WID_W+RECIP_W)'(cfg.width) * (WID_W+RECIP_W)'(mcol);
      h_prod = (HGT_W+RECIP_W)'(cfg.height) * (HGT_W+RECIP_W)'(mcol);
      wq_in  = w_prod[RECIP_SH+WID_W-1:RECIP_SH];
      hq_in  = h_prod[RECIP_SH+HGT_W-1:RECIP_SH];
   end

   // classification of the pixel held in the first stage
   always_comb begin
      c_prod = (COL_W+RECIP_W)'(f1_col_ff) * (COL_W+RECIP_W)'(mcol);
      r_prod = (ROW_W+RECIP_W)'(f1_row_ff) * (ROW_W+RECIP_W)'(mcol);
      g_prod = (GRAY_W+1)'(f1_s3_ff) * (GRAY_W+1)'(GRAY_RECIP);
      colq   = c_prod[RECIP_SH+COL_W-1:RECIP_SH];
      rowq   = r_prod[RECIP_SH+ROW_W-1:RECIP_SH];
      f_m1   = cfg.factor - FAC_W'(1);

      q_ent.column = colq;
      q_ent.first  = (f1_cib_ff == '0) && (f1_rib_ff == '0);
      q_ent.emit   = ({1'b0, f1_cib_ff} == f_m1) && ({1'b0, f1_rib_ff} == f_m1)
                     && ({1'b0, colq} < wq_ff) && ({1'b0, rowq} < hq_ff);
      q_ent.last   = ({1'b0, colq} == wq_ff - WID_W'(1))
                     && ({1'b0, rowq} == hq_ff - HGT_W'(1));
      q_ent.gray   = g_prod[GRAY_SH+PIX_W-1:GRAY_SH];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cp_ff       <= '0;
         rp_ff       <= '0;
         cib_ff      <= '0;
         rib_ff      <= '0;
         f1_valid_ff <= 1'b0;
      end else begin
         cp_ff       <= cp_in;
         rp_ff       <= rp_in;
         cib_ff      <= cib_in;
         rib_ff      <= rib_in;
         f1_valid_ff <= f1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      f1_col_ff <= f1_col_in;
      f1_row_ff <= f1_row_in;
      f1_cib_ff <= f1_cib_in;
      f1_rib_ff <= f1_rib_in;
      f1_s3_ff  <= f1_s3_in;
      wq_ff     <= wq_in;
      hq_ff     <= hq_in;
   end

endmodule

[rtl/core/gbd_fifo.sv]
// ---------------------------------------------------------------------------
// gbd_fifo
// Short queue of classified pixels between front and back.
// ---------------------------------------------------------------------------
module gbd_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  gbd_pkg::qent_type push_ent,
   output logic              full,
   input  logic              pop,
   output gbd_pkg::qent_type pop_ent,
   output logic              empty
);
   import gbd_pkg::*;

   qent_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;

   assign full    = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign pop_ent = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_ent;
      end
   end

endmodule

[rtl/core/gbd_back.sv]
// ---------------------------------------------------------------------------
// gbd_back
// Column accumulator read-modify-write, block average and result register.
// ---------------------------------------------------------------------------
module gbd_back (
   input  logic                      clock,
   input  logic                      reset,
   input  gbd_pkg::cfg_type          cfg,
   input  logic                      q_empty,
   input  gbd_pkg::qent_type         q_ent,
   output logic                      q_pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [gbd_pkg::PIX_W-1:0] rsp_gray_value,
   output logic                      rsp_frame_last
);
   import gbd_pkg::*;

   logic                  a_valid_ff, a_valid_in;
   qent_type              a_ent_ff, a_ent_in;
   logic                  fwd_valid_ff, fwd_valid_in;
   logic [COL_W-1:0]      fwd_idx_ff, fwd_idx_in;
   logic [SUM_W-1:0]      fwd_sum_ff, fwd_sum_in;
   logic                  p_valid_ff, p_valid_in;
   logic                  p_emit_ff, p_emit_in;
   logic                  p_last_ff, p_last_in;
   logic [SUM_W-1:0]      p_sum_ff, p_sum_in;
   logic [SQ_RECIP_W-1:0] p_recip_ff, p_recip_in;
   logic                  out_valid_ff, out_valid_in;
   logic [PIX_W-1:0]      out_gray_ff, out_gray_in;
   logic                  out_last_ff, out_last_in;

   logic                  out_ready;
   logic                  p_adv;
   logic                  p_ready;
   logic                  a_adv;
   logic                  a_ready;
   logic [SUM_W-1:0]      rd_data;
   logic [SUM_W-1:0]      base;
   logic [SUM_W-1:0]      sum;
   logic [SUM_W+SQ_RECIP_W-1:0] d_prod;

   gbd_ram #(
      .WIDTH (SUM_W),
      .DEPTH (MAX_INPUT_WIDTH)
   ) u_sums (
      .clock   (clock),
      .wr_en   (a_adv),
      .wr_addr (a_ent_ff.column),
      .wr_data (sum),
      .rd_en   (q_pop),
      .rd_addr (q_ent.column),
      .rd_data (rd_data)
   );

   assign out_ready = !out_valid_ff || !rsp_stall;
   assign p_adv     = p_valid_ff && (!p_emit_ff || out_ready);
   assign p_ready   = !p_valid_ff || p_adv;
   assign a_adv     = a_valid_ff && p_ready;
   assign a_ready   = !a_valid_ff || a_adv;
   assign q_pop     = !q_empty && a_ready;

   always_comb begin
      // a write in the cycle of this entry's read is not yet in the RAM word
      base   = (fwd_valid_ff && (fwd_idx_ff == a_ent_ff.column)) ? fwd_sum_ff : rd_data;
      sum    = a_ent_ff.first ? SUM_W'(a_ent_ff.gray) : base + SUM_W'(a_ent_ff.gray);
      d_prod = (SUM_W+SQ_RECIP_W)'(p_sum_ff) * (SUM_W+SQ_RECIP_W)'(p_recip_ff);

      a_valid_in = a_valid_ff;
      if (q_pop) begin
         a_valid_in = 1'b1;
      end else if (a_adv) begin
         a_valid_in = 1'b0;
      end
      a_ent_in = q_pop ? q_ent : a_ent_ff;

      fwd_valid_in = fwd_valid_ff;
      fwd_idx_in   = fwd_idx_ff;
      fwd_sum_in   = fwd_sum_ff;
      if (q_pop) begin
         fwd_valid_in = a_adv;
         fwd_idx_in   = a_ent_ff.column;
         fwd_sum_in   = sum;
      end

      p_valid_in = p_valid_ff;
      if (a_adv) begin
         p_valid_in = 1'b1;
      end else if (p_adv) begin
         p_valid_in = 1'b0;
      end
      p_emit_in  = a_adv ? a_ent_ff.emit : p_emit_ff;
      p_last_in  = a_adv ? a_ent_ff.last : p_last_ff;
      p_sum_in   = a_adv ? sum : p_sum_ff;
      p_recip_in = a_adv ? sq_recip(cfg.factor) : p_recip_ff;

      out_valid_in = out_valid_ff;
      out_gray_in  = out_gray_ff;
      out_last_in  = out_last_ff;
      if (p_adv && p_emit_ff) begin
         out_valid_in = 1'b1;
         out_gray_in  = d_prod[SQ_RECIP_SH+PIX_W-1:SQ_RECIP_SH];
         out_last_in  = p_last_ff;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         fwd_valid_ff <= 1'b0;
         p_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         fwd_valid_ff <= fwd_valid_in;
         p_valid_ff   <= p_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ent_ff    <= a_ent_in;
      fwd_idx_ff  <= fwd_idx_in;
      fwd_sum_ff  <= fwd_sum_in;
      p_emit_ff   <= p_emit_in;
      p_last_ff   <= p_last_in;
      p_sum_ff    <= p_sum_in;
      p_recip_ff  <= p_recip_in;
      out_gray_ff <= out_gray_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_gray_value = out_gray_ff;
   assign rsp_frame_last = out_last_ff;

endmodule

[rtl/core/gray_box_downscaler.sv]
// ---------------------------------------------------------------------------
// gray_box_downscaler
// Grayscale box-filter downsampler over RGB pixels in raster order.
// ---------------------------------------------------------------------------
// req_*: one RGB pixel per beat, taken when req_valid is high and req_stall
//   low. rsp_*: one averaged gray pixel per completed block, frame_last on
//   the final block of the frame. csr_*: register writes, always ready;
//   index 0 input_width, 1 input_height, 2 scale_factor; write only while idle.
// Throughput: one pixel per cycle while req_stall is low, set by the column-sum
//   RAM read-modify-write (one read and one write port, write forwarded to the
//   next read). A block's result passes the front stage, queue, accumulate,
//   average multiply and result register before it appears on rsp_*.
// req_stall rises only when the 4-entry queue is full; a stalled rsp_* beat
//   holds, and back pressure reaches req_stall after the queue fills.
// Reset: counters, queue and result register clear; registers return to
//   640 x 480, factor 1. Column sums need no clear: each block starts fresh.
// ---------------------------------------------------------------------------
`include "gray_box_downscaler_defines.svh"

module gray_box_downscaler (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [gbd_pkg::PIX_W-1:0]      req_red,
   input  logic [gbd_pkg::PIX_W-1:0]      req_green,
   input  logic [gbd_pkg::PIX_W-1:0]      req_blue,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [gbd_pkg::PIX_W-1:0]      rsp_gray_value,
   output logic                           rsp_frame_last,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [gbd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [gbd_pkg::CSR_DATA_W-1:0] csr_data
);
   import gbd_pkg::*;

   localparam logic [WID_W-1:0] WIDTH_RESET  = WID_W'(640);
   localparam logic [HGT_W-1:0] HEIGHT_RESET = HGT_W'(480);
   localparam logic [FAC_W-1:0] FACTOR_RESET = FAC_W'(1);
   localparam logic [FAC_W-1:0] MAX_FACTOR   = FAC_W'(16);
   localparam logic [HGT_W-1:0] MAX_HEIGHT   = HGT_W'(4096);

   logic [WID_W-1:0] iw_ff, iw_in;
   logic [HGT_W-1:0] ih_ff, ih_in;
   logic [FAC_W-1:0] sf_ff, sf_in;
   cfg_type          cfg;
   logic             q_push;
   logic             q_full;
   logic             q_pop;
   logic             q_empty;
   qent_type         push_ent;
   qent_type         pop_ent;

   assign csr_ready = 1'b1;

   always_comb begin
      iw_in = iw_ff;
      ih_in = ih_ff;
      sf_in = sf_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_INPUT_WIDTH:  iw_in = csr_data[WID_W-1:0];
            CSR_INPUT_HEIGHT: ih_in = csr_data[HGT_W-1:0];
            CSR_SCALE_FACTOR: sf_in = csr_data[FAC_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iw_ff <= WIDTH_RESET;
         ih_ff <= HEIGHT_RESET;
         sf_ff <= FACTOR_RESET;
      end else begin
         iw_ff <= iw_in;
         ih_ff <= ih_in;
         sf_ff <= sf_in;
      end
   end

   // clamp to the supported ranges
   always_comb begin
      cfg.factor = (sf_ff == '0) ? FAC_W'(1) : ((sf_ff > MAX_FACTOR) ? MAX_FACTOR : sf_ff);
      cfg.width  = (iw_ff == '0) ? WID_W'(1)
                 : ((iw_ff > WID_W'(MAX_INPUT_WIDTH)) ? WID_W'(MAX_INPUT_WIDTH) : iw_ff);
      cfg.height = (ih_ff == '0) ? HGT_W'(1) : ((ih_ff > MAX_HEIGHT) ? MAX_HEIGHT : ih_ff);
   end

   gbd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_red   (req_red),
      .req_green (req_green),
      .req_blue  (req_blue),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_ent     (push_ent)
   );

   gbd_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_ent (push_ent),
      .full     (q_full),
      .pop      (q_pop),
      .pop_ent  (pop_ent),
      .empty    (q_empty)
   );

   gbd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .q_empty        (q_empty),
      .q_ent          (pop_ent),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_gray_value (rsp_gray_value),
      .rsp_frame_last (rsp_frame_last)
   );

   `GBD_ASSERT_SAME(a_no_push_full, clock, reset, q_push, !q_full, "push into full queue")
   `GBD_ASSERT_SAME(a_no_pop_empty, clock, reset, q_pop, !q_empty, "pop from empty queue")
   `GBD_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid && !req_stall, "busy after reset")

endmodule
